// File: hdl/pfna_pkg.sv
// types, codes and helper functions shared by the marker front block
package pfna_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int CFG_DW         = 21;
  localparam int GAUSS_LEN      = 49;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_DEGEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_BASE_SPEED  = 3'd1,
    CFG_DIFFUSION   = 3'd2,
    CFG_BUMP_GAIN   = 3'd3,
    CFG_BUMP_CENTER = 3'd4,
    CFG_POINT_COUNT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         point_index;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_HRD,
    S_PRE_W, S_PRE_C, S_LD_CUR, S_RD_NXT, S_LD_NXT,
    S_WRAP, S_DIFF, S_SPD, S_A, S_NORM,
    S_SQA, S_SQB, S_SQC, S_SQRT,
    S_DIV_INIT, S_DIV, S_DIV_END,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_DWR,
    S_AP_RD, S_AP_WR
  } state_t;

  // round(65536*exp(-d*d/200))
  function automatic logic [16:0] gauss_lut(input logic [5:0] ad);
    logic [16:0] g;
    case (ad)
      6'd0:  g = 17'd65536; 6'd1:  g = 17'd65209; 6'd2:  g = 17'd64238;
      6'd3:  g = 17'd62652; 6'd4:  g = 17'd60497; 6'd5:  g = 17'd57835;
      6'd6:  g = 17'd54740; 6'd7:  g = 17'd51295; 6'd8:  g = 17'd47589;
      6'd9:  g = 17'd43711; 6'd10: g = 17'd39750; 6'd11: g = 17'd35787;
      6'd12: g = 17'd31900; 6'd13: g = 17'd28151; 6'd14: g = 17'd24596;
      6'd15: g = 17'd21276; 6'd16: g = 17'd18221; 6'd17: g = 17'd15450;
      6'd18: g = 17'd12969; 6'd19: g = 17'd10779; 6'd20: g = 17'd8869;
      6'd21: g = 17'd7225;  6'd22: g = 17'd5828;  6'd23: g = 17'd4653;
      6'd24: g = 17'd3679;  6'd25: g = 17'd2879;  6'd26: g = 17'd2231;
      6'd27: g = 17'd1712;  6'd28: g = 17'd1300;  6'd29: g = 17'd978;
      6'd30: g = 17'd728;   6'd31: g = 17'd537;   6'd32: g = 17'd392;
      6'd33: g = 17'd283;   6'd34: g = 17'd202;   6'd35: g = 17'd143;
      6'd36: g = 17'd101;   6'd37: g = 17'd70;    6'd38: g = 17'd48;
      6'd39: g = 17'd33;    6'd40: g = 17'd22;    6'd41: g = 17'd15;
      6'd42: g = 17'd10;    6'd43: g = 17'd6;     6'd44: g = 17'd4;
      6'd45: g = 17'd3;     6'd46: g = 17'd2;     6'd47: g = 17'd1;
      6'd48: g = 17'd1;
      default: g = 17'd0;
    endcase
    return g;
  endfunction

  // shift right by 16, rounding halves away from zero
  function automatic logic signed [66:0] rnd16(input logic signed [66:0] v);
    logic [66:0] m;
    m = v[66] ? 67'(-v) : 67'(v);
    m = (m + 67'd32768) >> 16;
    return v[66] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] s;
    if (v[66:31] == '0 || v[66:31] == '1) s = v[31:0];
    else if (v[66]) s = 32'sh8000_0000;
    else s = 32'sh7FFF_FFFF;
    return s;
  endfunction

endpackage

// File: hdl/periodic_front_normal_advance.sv
// marker front ring: point store, per-point delta sequencer and apply sweep
// a step computes each point's delta with a 31-step square root and two 17-step
// divisions sharing one iterative unit, then sweeps the ring to apply the deltas;
// a zero tangent point skips the square root and the divisions.
// one item at a time; the result strobe lasts one cycle and cannot be stalled.
// reset restores the register defaults; point memories hold nothing until written.
module periodic_front_normal_advance
  import pfna_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_word_t          in_word,
  output logic              out_strobe,
  output out_word_t         out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > 11) ? NW : 11;

  // configuration
  logic [16:0] ts_r;
  logic [20:0] v0_r, diff_r, gain_r;
  logic [9:0]  bc_r;
  logic [10:0] pc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r   <= 17'd655;
      v0_r   <= 21'd65536;
      diff_r <= 21'd0;
      gain_r <= 21'd3277;
      bc_r   <= 10'd500;
      pc_r   <= 11'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIME_STEP:   ts_r   <= cfg_data[16:0];
        CFG_BASE_SPEED:  v0_r   <= cfg_data[20:0];
        CFG_DIFFUSION:   diff_r <= cfg_data[20:0];
        CFG_BUMP_GAIN:   gain_r <= cfg_data[20:0];
        CFG_BUMP_CENTER: bc_r   <= cfg_data[9:0];
        CFG_POINT_COUNT: pc_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // points in use
  logic [CW-1:0] pc_w, n_c;
  logic [NW-1:0] n_w, nm1_w;
  logic signed [33:0] len_w, half_w;

  always_comb begin
    pc_w = CW'(pc_r);
    if (pc_w < CW'(3)) n_c = CW'(3);
    else if (pc_w > CW'(MAX_POINTS)) n_c = CW'(MAX_POINTS);
    else n_c = pc_w;
  end
  assign n_w    = n_c[NW-1:0];
  assign nm1_w  = n_w - NW'(1);
  assign len_w  = $signed(34'(n_w) << 16);
  assign half_w = $signed(34'(n_w) << 15);

  // memories
  logic [63:0] pmem [MAX_POINTS];
  logic [63:0] dmem [MAX_POINTS];
  logic [63:0] prd_r, drd_r;
  logic [AW-1:0] pr_addr, pw_addr;
  logic [63:0] pw_data, dw_data;
  logic pw_en, dw_en;

  // sequencer state and datapath
  state_t state_r, state_nxt;
  logic [NW-1:0] ci_r, ci_inc;
  logic deg_r, rd_bad_r;
  logic out_strobe_r, out_strobe_nxt;
  out_word_t out_word_r, out_word_nxt;

  logic signed [31:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r, nxt_x_r, nxt_y_r;
  logic signed [33:0] xu_r, xw_r;
  logic [33:0] ax_r, ay_r;
  logic tneg_x_r, tneg_y_r;
  logic signed [35:0] lapx_r, lapy_r;
  logic [22:0] speed_r, b_r;
  logic [24:0] a_r;
  logic signed [66:0] prod_r;
  logic [61:0] v_r, r_r, bit_r;
  logic [4:0] cnt_r;
  logic [46:0] rem_r, dvs_r;
  logic [16:0] q_r;
  logic divy_r;
  logic signed [17:0] ux_r, uy_r;
  logic signed [44:0] t1_r, dx_r, dy_r;

  logic signed [35:0] mul_a;
  logic signed [30:0] mul_b;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;
  assign ci_inc     = ci_r + NW'(1);

  // host address and range check
  logic [AW+9:0] hidx_w;
  logic [AW-1:0] haddr_w;
  logic hok_w;
  assign hidx_w  = {{AW{1'b0}}, in_word.point_index};
  assign haddr_w = hidx_w[AW-1:0];
  assign hok_w   = CW'(in_word.point_index) < n_c;

  // neighbor after ci, wrapping at the ring end
  logic [AW-1:0] u_addr;
  assign u_addr = (ci_inc == n_w) ? '0 : ci_inc[AW-1:0];

  // speed bump lookup
  logic signed [CW:0] d_w, ad_w;
  logic [16:0] g_w;
  assign d_w  = $signed({1'b0, CW'(ci_r)}) - $signed({1'b0, CW'(bc_r)});
  assign ad_w = d_w[CW] ? -d_w : d_w;
  assign g_w  = (ad_w < (CW+1)'(GAUSS_LEN)) ? gauss_lut(ad_w[5:0]) : 17'd0;

  // minimum image neighbors
  logic signed [32:0] du_w, dwn_w;
  logic signed [33:0] xu_w, xw_w;
  assign du_w  = 33'(nxt_x_r) - 33'(cur_x_r);
  assign dwn_w = 33'(prev_x_r) - 33'(cur_x_r);
  assign xu_w  = 34'(nxt_x_r) + ((34'(du_w) < -half_w) ? len_w : 34'sd0);
  assign xw_w  = 34'(prev_x_r) - ((34'(dwn_w) > half_w) ? len_w : 34'sd0);

  // differences
  logic signed [33:0] tx_w, ty_w;
  logic signed [35:0] lapx_w, lapy_w;
  assign tx_w   = xu_r - xw_r;
  assign ty_w   = 34'(nxt_y_r) - 34'(prev_y_r);
  assign lapx_w = 36'(xu_r) + 36'(xw_r) - (36'(cur_x_r) <<< 1);
  assign lapy_w = 36'(nxt_y_r) + 36'(prev_y_r) - (36'(cur_y_r) <<< 1);

  logic [33:0] m_w;
  assign m_w = (ax_r > ay_r) ? ax_r : ay_r;

  logic [61:0] rb_w;
  assign rb_w = r_r + bit_r;

  logic [33:0] dsel_w;
  assign dsel_w = divy_r ? ay_r : ax_r;

  logic signed [66:0] rnd_w;
  assign rnd_w = rnd16(prod_r);

  // apply arithmetic
  logic signed [31:0] px_w, py_w, dxm_w, dym_w;
  logic signed [33:0] x0_w, x1_w, x2_w;
  logic signed [32:0] y0_w;
  assign px_w  = prd_r[63:32];
  assign py_w  = prd_r[31:0];
  assign dxm_w = drd_r[63:32];
  assign dym_w = drd_r[31:0];
  assign x0_w  = 34'(px_w) + 34'(dxm_w);
  assign x1_w  = (x0_w > len_w) ? x0_w - len_w : x0_w;
  assign x2_w  = x1_w[33] ? x1_w + len_w : x1_w;
  assign y0_w  = 33'(py_w) + 33'(dym_w);

  always_ff @(posedge clk) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    prd_r <= pmem[pr_addr];
    if (dw_en) dmem[ci_r[AW-1:0]] <= dw_data;
    drd_r <= dmem[ci_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  // next state, memory controls, multiplier operands and result word
  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    pr_addr        = ci_r[AW-1:0];
    pw_en          = 1'b0;
    pw_addr        = ci_r[AW-1:0];
    pw_data        = {sat32(67'(x2_w)), sat32(67'(y0_w))};
    dw_en          = 1'b0;
    dw_data        = {sat32(67'(dx_r)), sat32(67'(dy_r))};
    mul_a          = '0;
    mul_b          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pr_addr = haddr_w;
          case (in_word.req_type)
            REQ_WRITE: begin
              pw_en          = hok_w;
              pw_addr        = haddr_w;
              pw_data        = {in_word.pos_x_in, in_word.pos_y_in};
              out_strobe_nxt = 1'b1;
              out_word_nxt   = '{32'sd0, 32'sd0, hok_w ? STAT_OK : STAT_RANGE};
            end
            REQ_READ: state_nxt = S_HRD;
            REQ_STEP: state_nxt = S_PRE_W;
            default: begin
              out_strobe_nxt = 1'b1;
              out_word_nxt   = '{32'sd0, 32'sd0, STAT_OK};
            end
          endcase
        end
      end
      S_HRD: begin
        out_strobe_nxt = 1'b1;
        if (rd_bad_r) out_word_nxt = '{32'sd0, 32'sd0, STAT_RANGE};
        else out_word_nxt = '{prd_r[63:32], prd_r[31:0], STAT_OK};
        state_nxt = S_IDLE;
      end
      S_PRE_W: begin
        pr_addr   = nm1_w[AW-1:0];
        state_nxt = S_PRE_C;
      end
      S_PRE_C: begin
        pr_addr   = '0;
        state_nxt = S_LD_CUR;
      end
      S_LD_CUR: state_nxt = S_RD_NXT;
      S_RD_NXT: begin
        pr_addr   = u_addr;
        state_nxt = S_LD_NXT;
      end
      S_LD_NXT: state_nxt = S_WRAP;
      S_WRAP: begin
        mul_a     = $signed(36'(gain_r));
        mul_b     = $signed(31'(g_w));
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        mul_a     = $signed(36'(diff_r));
        mul_b     = $signed(31'(ts_r));
        state_nxt = S_SPD;
      end
      S_SPD: begin
        mul_a     = $signed(36'(speed_r));
        mul_b     = $signed(31'(ts_r));
        state_nxt = S_A;
      end
      S_A: state_nxt = (m_w == '0) ? S_DWR : S_NORM;
      S_NORM: begin
        if (m_w < 34'(1) << 30 && m_w >= 34'(1) << 29) state_nxt = S_SQA;
      end
      S_SQA: begin
        mul_a     = $signed(36'(ax_r));
        mul_b     = $signed(ax_r[30:0]);
        state_nxt = S_SQB;
      end
      S_SQB: begin
        mul_a     = $signed(36'(ay_r));
        mul_b     = $signed(ay_r[30:0]);
        state_nxt = S_SQC;
      end
      S_SQC: state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == 5'd30) state_nxt = S_DIV_INIT;
      S_DIV_INIT: state_nxt = S_DIV;
      S_DIV: if (cnt_r == 5'd16) state_nxt = S_DIV_END;
      S_DIV_END: state_nxt = divy_r ? S_M1 : S_DIV_INIT;
      S_M1: begin
        mul_a     = $signed(36'(a_r));
        mul_b     = 31'(uy_r);
        state_nxt = S_M2;
      end
      S_M2: begin
        mul_a     = lapx_r;
        mul_b     = $signed(31'(b_r));
        state_nxt = S_M3;
      end
      S_M3: begin
        mul_a     = $signed(36'(a_r));
        mul_b     = 31'(ux_r);
        state_nxt = S_M4;
      end
      S_M4: begin
        mul_a     = lapy_r;
        mul_b     = $signed(31'(b_r));
        state_nxt = S_M5;
      end
      S_M5: state_nxt = S_DWR;
      S_DWR: begin
        dw_en     = 1'b1;
        state_nxt = (ci_inc == n_w) ? S_AP_RD : S_RD_NXT;
      end
      S_AP_RD: state_nxt = S_AP_WR;
      S_AP_WR: begin
        pw_en = 1'b1;
        if (ci_inc == n_w) begin
          state_nxt      = S_IDLE;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{32'sd0, 32'sd0, deg_r ? STAT_DEGEN : STAT_OK};
        end else begin
          state_nxt = S_AP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 67'(mul_a) * 67'(mul_b);
    if (!rst_n) begin
      ci_r  <= '0;
      deg_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          ci_r     <= '0;
          deg_r    <= 1'b0;
          rd_bad_r <= !hok_w;
          divy_r   <= 1'b0;
        end
        S_PRE_C:  {prev_x_r, prev_y_r} <= prd_r;
        S_LD_CUR: {cur_x_r, cur_y_r} <= prd_r;
        S_LD_NXT: {nxt_x_r, nxt_y_r} <= prd_r;
        S_WRAP: begin
          xu_r <= xu_w;
          xw_r <= xw_w;
        end
        S_DIFF: begin
          speed_r  <= 23'(v0_r) + 23'((prod_r[37:0] + 38'd32768) >> 16);
          tneg_x_r <= tx_w[33];
          tneg_y_r <= ty_w[33];
          ax_r     <= tx_w[33] ? 34'(-tx_w) : 34'(tx_w);
          ay_r     <= ty_w[33] ? 34'(-ty_w) : 34'(ty_w);
          lapx_r   <= lapx_w;
          lapy_r   <= lapy_w;
        end
        S_SPD: b_r <= 23'((prod_r[37:0] + 38'd32768) >> 16);
        S_A: begin
          a_r <= 25'((prod_r[39:0] + 40'd32768) >> 16);
          if (m_w == '0) begin
            deg_r <= 1'b1;
            dx_r  <= '0;
            dy_r  <= '0;
          end
        end
        S_NORM: begin
          if (m_w >= 34'(1) << 30) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else if (m_w < 34'(1) << 29) begin
            ax_r <= ax_r << 1;
            ay_r <= ay_r << 1;
          end
        end
        S_SQB: v_r <= prod_r[61:0];
        S_SQC: begin
          v_r   <= v_r + prod_r[61:0];
          r_r   <= '0;
          bit_r <= 62'(1) << 60;
          cnt_r <= '0;
        end
        S_SQRT: begin
          if (v_r >= rb_w) begin
            v_r <= v_r - rb_w;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
        end
        S_DIV_INIT: begin
          // rounded quotient: add half the divisor up front
          rem_r <= {dsel_w[30:0], 16'b0} + 47'(r_r[30:1]);
          dvs_r <= {r_r[30:0], 16'b0};
          q_r   <= '0;
          cnt_r <= '0;
        end
        S_DIV: begin
          if (rem_r >= dvs_r) begin
            rem_r <= rem_r - dvs_r;
            q_r   <= {q_r[15:0], 1'b1};
          end else begin
            q_r <= {q_r[15:0], 1'b0};
          end
          dvs_r <= dvs_r >> 1;
          cnt_r <= cnt_r + 5'd1;
        end
        S_DIV_END: begin
          if (divy_r) uy_r <= tneg_y_r ? -$signed(18'(q_r)) : $signed(18'(q_r));
          else ux_r <= tneg_x_r ? -$signed(18'(q_r)) : $signed(18'(q_r));
          divy_r <= !divy_r;
        end
        S_M2: t1_r <= rnd_w[44:0];
        S_M3: dx_r <= rnd_w[44:0] - t1_r;
        S_M4: t1_r <= rnd_w[44:0];
        S_M5: dy_r <= t1_r + rnd_w[44:0];
        S_DWR: begin
          {prev_x_r, prev_y_r} <= {cur_x_r, cur_y_r};
          {cur_x_r, cur_y_r}   <= {nxt_x_r, nxt_y_r};
          ci_r <= (ci_inc == n_w) ? '0 : ci_inc;
        end
        S_AP_WR: ci_r <= (ci_inc == n_w) ? '0 : ci_inc;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/pfna_checker.sv
// port level checks of the marker front block and their binding
module pfna_checker
  import pfna_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_strobe,
  input out_word_t out_word
);

  logic acc;
  assign acc = rst_n && start && !busy;

  a_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_word.req_type == REQ_WRITE |=> out_strobe && !busy)
    else $error("write word not answered in the next cycle");

  a_read_timing: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_word.req_type == REQ_READ |=> busy && !out_strobe ##1 out_strobe)
    else $error("read word not answered after two cycles");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_word.req_type == REQ_STEP |=> busy && !out_strobe)
    else $error("step did not hold the block busy");

  a_zero_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.status != STAT_OK |->
      out_word.pos_x_out == 0 && out_word.pos_y_out == 0)
    else $error("nonzero coordinates with error status");

endmodule

bind periodic_front_normal_advance pfna_checker u_pfna_checker (.*);

// File: tb/periodic_front_normal_advance_tb.sv
// testbench for the marker front block: queued stimulus, bit-exact prediction, result checks
module periodic_front_normal_advance_tb;
  import pfna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_UNUSED = 3'd6;
  localparam int QUIET_CYCLES = 8;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [20:0] data;
    in_word_t    w;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_strobe;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  periodic_front_normal_advance dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ring model
  longint dt_r, v0_r, diff_r, gain_r, center_r, count_r;
  longint ring_x[1024], ring_y[1024];
  out_word_t expected_q[$];
  job_t job_q[$];
  int errors = 0;

  const longint unsigned GAUSS[49] = '{
    65536, 65209, 64238, 62652, 60497, 57835, 54740, 51295, 47589, 43711,
    39750, 35787, 31900, 28151, 24596, 21276, 18221, 15450, 12969, 10779,
    8869, 7225, 5828, 4653, 3679, 2879, 2231, 1712, 1300, 978,
    728, 537, 392, 283, 202, 143, 101, 70, 48, 33,
    22, 15, 10, 6, 4, 3, 2, 1, 1};

  function automatic longint round_shift16(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 32768) >>> 16;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int active_points();
    if (count_r < 3) return 3;
    if (count_r > 1024) return 1024;
    return int'(count_r);
  endfunction

  // one time step of the whole ring; returns 1 on a zero tangent
  function automatic bit advance_ring();
    longint dlx[1024], dly[1024];
    int n, u, w;
    longint len, half, xi, xu, xw, yi, yu, yw, tx, ty, ux, uy, a, b, spd, d, x;
    longint unsigned ax, ay, m, r, g;
    bit degen;
    n = active_points();
    len = longint'(n) << 16;
    half = longint'(n) << 15;
    degen = 0;
    for (int i = 0; i < n; i++) begin
      u = (i + 1 == n) ? 0 : i + 1;
      w = (i == 0) ? n - 1 : i - 1;
      xi = ring_x[i]; xu = ring_x[u]; xw = ring_x[w];
      yi = ring_y[i]; yu = ring_y[u]; yw = ring_y[w];
      if (xu - xi < -half) xu += len;
      if (xw - xi > half) xw -= len;
      tx = xu - xw;
      ty = yu - yw;
      ax = (tx < 0) ? -tx : tx;
      ay = (ty < 0) ? -ty : ty;
      m = (ax > ay) ? ax : ay;
      if (m == 0) begin
        dlx[i] = 0;
        dly[i] = 0;
        degen = 1;
        continue;
      end
      while (m >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; m >>= 1; end
      while (m < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; m <<= 1; end
      r = int_sqrt(ax * ax + ay * ay);
      ux = ((ax << 16) + r / 2) / r;
      uy = ((ay << 16) + r / 2) / r;
      if (tx < 0) ux = -ux;
      if (ty < 0) uy = -uy;
      d = longint'(i) - center_r;
      if (d < 0) d = -d;
      g = (d < 49) ? GAUSS[d] : 0;
      spd = v0_r + ((gain_r * g + 32768) >> 16);
      a = (dt_r * spd + 32768) >> 16;
      b = (diff_r * dt_r + 32768) >> 16;
      dlx[i] = clip32(-round_shift16(a * uy) + round_shift16(b * (xu + xw - 2 * xi)));
      dly[i] = clip32(round_shift16(a * ux) + round_shift16(b * (yu + yw - 2 * yi)));
    end
    for (int i = 0; i < n; i++) begin
      x = ring_x[i] + dlx[i];
      if (x > len) x -= len;
      if (x < 0) x += len;
      ring_x[i] = clip32(x);
      ring_y[i] = clip32(ring_y[i] + dly[i]);
    end
    return degen;
  endfunction

  function automatic out_word_t ring_response(in_word_t w);
    out_word_t r;
    int n;
    r = '0;
    r.status = STAT_OK;
    n = active_points();
    if (w.req_type == REQ_WRITE || w.req_type == REQ_READ) begin
      if (int'(w.point_index) >= n) r.status = STAT_RANGE;
      else if (w.req_type == REQ_WRITE) begin
        ring_x[w.point_index] = longint'(w.pos_x_in);
        ring_y[w.point_index] = longint'(w.pos_y_in);
      end else begin
        r.pos_x_out = ring_x[w.point_index][31:0];
        r.pos_y_out = ring_y[w.point_index][31:0];
      end
    end else if (w.req_type == REQ_STEP) begin
      if (advance_ring()) r.status = STAT_DEGEN;
    end
    return r;
  endfunction

  // monitor: handshakes and result check at the rising edge
  bit word_taken = 0, cfg_taken = 0;
  always @(posedge clk) begin
    out_word_t e;
    word_taken = start && !busy;
    cfg_taken = cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_taken) begin
        case (cfg_index)
          CFG_TIME_STEP:   dt_r = cfg_data[16:0];
          CFG_BASE_SPEED:  v0_r = cfg_data;
          CFG_DIFFUSION:   diff_r = cfg_data;
          CFG_BUMP_GAIN:   gain_r = cfg_data;
          CFG_BUMP_CENTER: center_r = cfg_data[9:0];
          CFG_POINT_COUNT: count_r = cfg_data[10:0];
          default: ;
        endcase
      end
      if (word_taken) expected_q = {expected_q, ring_response(in_word)};
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h status=%0d", $time,
                   out_word.pos_x_out, out_word.pos_y_out, out_word.status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_word.pos_x_out !== e.pos_x_out) begin
            $display("%0t: pos_x_out expected %h actual %h", $time, e.pos_x_out,
                     out_word.pos_x_out);
            errors++;
          end
          if (out_word.pos_y_out !== e.pos_y_out) begin
            $display("%0t: pos_y_out expected %h actual %h", $time, e.pos_y_out,
                     out_word.pos_y_out);
            errors++;
          end
          if (out_word.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_word.status);
            errors++;
          end
        end
      end
    end
  end

  // driver: bursts of words with gaps, config writes only when the block is quiet
  int quiet_cnt = 0, gap_left = 0, burst_left = 4;
  always @(negedge clk) begin
    logic nx;
    bit cfg_open;
    job_t j;
    if (rst_n) begin
      if (expected_q.size() == 0 && !busy && !start && !cfg_valid) quiet_cnt++;
      else quiet_cnt = 0;
      nx = start;
      if (start && word_taken) nx = 1'b0;
      cfg_open = cfg_valid && !cfg_taken;
      if (cfg_valid && cfg_taken) cfg_valid <= 1'b0;
      if (!nx && !cfg_open && job_q.size() > 0) begin
        if (gap_left > 0) gap_left--;
        else begin
          j = job_q[0];
          if (j.is_cfg) begin
            if (quiet_cnt >= QUIET_CYCLES) begin
              void'(job_q.pop_front());
              cfg_index <= j.idx;
              cfg_data <= j.data;
              cfg_valid <= 1'b1;
            end
          end else begin
            void'(job_q.pop_front());
            in_word <= j.w;
            nx = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 12);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
      end
      start <= nx;
    end
  end

  // stimulus bookkeeping
  int gen_n = 1000;
  bit written[1024];

  task automatic put_cfg(logic [2:0] idx, logic [20:0] data);
    job_t j;
    j = '{default: '0};
    j.is_cfg = 1;
    j.idx = idx;
    j.data = data;
    job_q = {job_q, j};
    if (idx == CFG_POINT_COUNT) begin
      gen_n = data[10:0];
      if (gen_n < 3) gen_n = 3;
      if (gen_n > 1024) gen_n = 1024;
    end
  endtask

  task automatic put_word(logic [1:0] req, int idx, logic [31:0] x, logic [31:0] y);
    job_t j;
    j = '{default: '0};
    j.w.req_type = req;
    j.w.point_index = idx[9:0];
    j.w.pos_x_in = x;
    j.w.pos_y_in = y;
    job_q = {job_q, j};
    if (req == REQ_WRITE && idx < gen_n) written[idx] = 1;
  endtask

  function automatic bit ring_ready();
    for (int i = 0; i < gen_n; i++) if (!written[i]) return 0;
    return 1;
  endfunction

  // a well-formed front: points march along x with small wobble
  task automatic write_front();
    longint x;
    for (int i = 0; i < gen_n; i++) begin
      x = (longint'(i) << 16) + $signed($urandom_range(0, 32768)) - 16384;
      if (x < 0) x += longint'(gen_n) << 16;
      put_word(REQ_WRITE, i, x[31:0], 32'($signed($urandom_range(0, 4194304)) - 2097152));
    end
  endtask

  task automatic random_word();
    int k, idx;
    k = $urandom_range(0, 99);
    if (k < 45 && ring_ready()) put_word(REQ_STEP, $urandom_range(0, 1023), $urandom, $urandom);
    else if (k < 65) begin
      idx = $urandom_range(0, gen_n - 1);
      if (written[idx]) put_word(REQ_READ, idx, $urandom, $urandom);
      else if (gen_n < 1024) put_word(REQ_READ, $urandom_range(gen_n, 1023), 0, 0);
      else put_word(REQ_WRITE, idx, 32'($urandom_range(0, gen_n * 65536)), $urandom);
    end else if (k < 85)
      put_word(REQ_WRITE, $urandom_range(0, gen_n - 1),
               32'($urandom_range(0, gen_n * 65536)), $urandom);
    else if (k < 90) put_word(REQ_WRITE, $urandom_range(0, 1023), $urandom, $urandom);
    else if (k < 95) put_word(2'd3, $urandom_range(0, 1023), $urandom, $urandom);
    else begin
      idx = $urandom_range(0, 1023) | 32'h200;
      if (idx < gen_n && !written[idx]) put_word(REQ_WRITE, idx, $urandom, $urandom);
      else put_word(REQ_READ, idx, $urandom, $urandom);
    end
  endtask

  initial begin
    int cnt;
    dt_r = 655; v0_r = 65536; diff_r = 0; gain_r = 3277; center_r = 500; count_r = 1000;
    foreach (written[i]) written[i] = 0;

    // defaults: range checks, unused selector, boundary values
    put_word(REQ_WRITE, 999, 32'h7FFF_FFFF, 32'h8000_0000);
    put_word(REQ_READ, 999, 0, 0);
    put_word(REQ_WRITE, 1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_word(REQ_READ, 1023, 0, 0);
    put_word(2'd3, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_word(REQ_WRITE, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    put_word(REQ_READ, 0, 0, 0);

    // smallest ring, extreme rates
    put_cfg(CFG_POINT_COUNT, 0);
    put_cfg(CFG_TIME_STEP, 65536);
    put_cfg(CFG_BASE_SPEED, 1048576);
    put_cfg(CFG_DIFFUSION, 1048576);
    put_cfg(CFG_BUMP_GAIN, 1048576);
    put_cfg(CFG_BUMP_CENTER, 1);
    put_cfg(CFG_UNUSED, 21'h1FFFFF);
    put_word(REQ_WRITE, 3, 0, 0);
    // all points coincide: zero tangent
    for (int i = 0; i < 3; i++) put_word(REQ_WRITE, i, 32'h0001_0000, 32'h0000_1000);
    put_word(REQ_STEP, 0, 0, 0);
    put_word(REQ_READ, 1, 0, 0);
    // near the top of y and the edge of x: saturation and wrap
    put_word(REQ_WRITE, 0, 32'h0002_FFF0, 32'h7FFF_FF00);
    put_word(REQ_WRITE, 1, 32'h0000_0010, 32'h7FFF_FFF0);
    put_word(REQ_WRITE, 2, 32'h0001_8000, 32'h8000_0010);
    put_word(REQ_STEP, 0, 0, 0);
    put_word(REQ_STEP, 0, 0, 0);
    for (int i = 0; i < 3; i++) put_word(REQ_READ, i, 0, 0);

    // largest ring, point access only
    put_cfg(CFG_POINT_COUNT, 2047);
    put_word(REQ_WRITE, 1023, 32'h1234_5678, 32'h8765_4321);
    put_word(REQ_READ, 1023, 0, 0);
    for (int k = 0; k < 10; k++) random_word();

    // random settings, mostly small rings
    for (int ph = 0; ph < 12; ph++) begin
      put_cfg(CFG_TIME_STEP, (ph % 4 == 0) ? 0 : $urandom_range(0, 65536));
      put_cfg(CFG_BASE_SPEED, (ph % 5 == 1) ? 0 : $urandom_range(0, 1048576));
      put_cfg(CFG_DIFFUSION, (ph % 3 == 0) ? 0 : $urandom_range(0, 1048576));
      put_cfg(CFG_BUMP_GAIN, $urandom_range(0, 1048576));
      put_cfg(CFG_BUMP_CENTER, (ph % 4 == 3) ? $urandom_range(0, 1023) : $urandom_range(0, 20));
      put_cfg(CFG_POINT_COUNT, (ph == 7) ? 24 : $urandom_range(3, 12));
      write_front();
      cnt = 0;
      while (cnt < 34) begin
        random_word();
        cnt++;
      end
    end
    put_cfg(CFG_POINT_COUNT, 1024);
    for (int k = 0; k < 20; k++) random_word();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (job_q.size() != 0 || start || cfg_valid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/pfna_pkg.sv
hdl/periodic_front_normal_advance.sv
hdl/pfna_checker.sv
tb/periodic_front_normal_advance_tb.sv
